### design/urfw_pkg.sv
// ----------------------------------------------------------------------------
// urfw_pkg
// Shared types, codes and helpers for the UART ring FIFO block.
// ----------------------------------------------------------------------------
package urfw_pkg;

  localparam int unsigned RX_DEPTH_DEF = 256;
  localparam int unsigned TX_DEPTH_DEF = 256;

  // Largest usable capacity, as a count and as a register value.
  localparam int unsigned CAP_MAX       = 256;
  localparam int unsigned CNT_W         = 9;
  localparam logic [CNT_W-1:0] CAP_LIMIT = 9'd256;

  typedef enum logic [2:0] {
    OP_LINE_RX    = 3'd0,
    OP_IDLE       = 3'd1,
    OP_TX_READY   = 3'd2,
    OP_HOST_READ  = 3'd3,
    OP_HOST_WRITE = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    EVT_NONE = 2'd0,
    EVT_HALF = 2'd1,
    EVT_FULL = 2'd2,
    EVT_IDLE = 2'd3
  } rx_evt_t;

  typedef enum logic {
    REG_RX_CAP = 1'b0,
    REG_TX_CAP = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       data_out;
    logic             data_valid;
    logic             accepted;
    logic [1:0]       rx_event;
    logic             tx_done;
    logic [CNT_W-1:0] rx_level;
    logic [CNT_W-1:0] tx_level;
  } out_item_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } fifo_ctrl_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] count_nxt;
    logic [CNT_W-1:0] cap;
  } fifo_stat_t;

  // Zero reads as one; anything above the hardware limit saturates.
  function automatic logic [CNT_W-1:0] clamp_cap(logic [CNT_W-1:0] v, int unsigned lim);
    logic [CNT_W-1:0] c;
    c = v;
    if (c == '0) c = 9'd1;
    if (c > CAP_LIMIT) c = CAP_LIMIT;
    if (32'(c) > lim) c = CNT_W'(lim);
    return c;
  endfunction

endpackage

### design/uart_ring_fifo_with_watermarks.sv
// ----------------------------------------------------------------------------
// uart_ring_fifo_with_watermarks
// Receive and transmit byte ring FIFOs of a serial port, with watermark events.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                              Direction  Moves
//   input     in_valid, in_stall, in_data        in         operation, data_in
//   result    out_valid, out_stall, out_data     out        one result per input
//   config    cfg_we, cfg_index, cfg_data        in         capacity writes
//
// A transaction is accepted into the input register and decoded there; once
// the output register can take it, it updates the FIFO it addresses and its
// result enters the output register. One transaction per cycle is sustained
// while out_stall is low; each FIFO memory has one write and one read port.
// Reset clears all pointers and counts and sets both capacities to the
// smaller of 256 and the FIFO depth; the memories need no clearing pass.
// While out_stall holds a result, the input register may still fill, and
// in_stall rises only when both registers are occupied.
//
module uart_ring_fifo_with_watermarks import urfw_pkg::*; #(
  parameter int unsigned RX_DEPTH = RX_DEPTH_DEF,
  parameter int unsigned TX_DEPTH = TX_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CNT_W-1:0] cfg_data
);

  // Result fields that do not come from a FIFO read register.
  typedef struct packed {
    logic             data_valid;
    logic             src_tx;
    logic             accepted;
    logic [1:0]       rx_event;
    logic             tx_done;
    logic [CNT_W-1:0] rx_level;
    logic [CNT_W-1:0] tx_level;
  } out_meta_t;

  logic       s1_valid_r, s1_valid_nxt;
  in_item_t   s1_item_r;
  logic       out_valid_r, out_valid_nxt;
  out_meta_t  meta_r, meta_nxt;
  logic       advance, fire, in_take;

  fifo_ctrl_t rx_ctrl, tx_ctrl;
  fifo_stat_t rx_stat, tx_stat;
  logic [7:0] rx_rd, tx_rd;
  logic [CNT_W-1:0] rx_half, rx_after_push;

  // The input register moves on whenever the output register is empty or
  // is being emptied in this cycle.
  assign advance  = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign rx_half       = rx_stat.cap >> 1;
  assign rx_after_push = rx_stat.count + 9'd1;

  // Decode the held transaction and any config write into FIFO commands and result flags.
  always_comb begin
    rx_ctrl       = '0;
    tx_ctrl       = '0;
    rx_ctrl.clear = cfg_we && (cfg_index == REG_RX_CAP);
    tx_ctrl.clear = cfg_we && (cfg_index == REG_TX_CAP);
    meta_nxt      = '0;
    if (fire) begin
      case (op_t'(s1_item_r.operation))
        OP_LINE_RX: begin
          if (rx_stat.count < rx_stat.cap) begin
            rx_ctrl.push      = 1'b1;
            meta_nxt.accepted = 1'b1;
            if (rx_after_push == rx_stat.cap) meta_nxt.rx_event = EVT_FULL;
            else if (rx_after_push > rx_half) meta_nxt.rx_event = EVT_HALF;
          end
        end
        OP_IDLE: begin
          if (rx_stat.count <= rx_half) meta_nxt.rx_event = EVT_IDLE;
        end
        OP_TX_READY: begin
          if (tx_stat.count != '0) begin
            tx_ctrl.pop         = 1'b1;
            meta_nxt.data_valid = 1'b1;
            meta_nxt.src_tx     = 1'b1;
            meta_nxt.tx_done    = (tx_stat.count == 9'd1);
          end
        end
        OP_HOST_READ: begin
          if (rx_stat.count != '0) begin
            rx_ctrl.pop         = 1'b1;
            meta_nxt.data_valid = 1'b1;
          end
        end
        OP_HOST_WRITE: begin
          if (tx_stat.count < tx_stat.cap) begin
            tx_ctrl.push      = 1'b1;
            meta_nxt.accepted = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    // Levels are taken after the pointer update, whatever the operation.
    meta_nxt.rx_level = rx_stat.count_nxt;
    meta_nxt.tx_level = tx_stat.count_nxt;
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) s1_valid_nxt = 1'b1;
    else if (advance) s1_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (advance) out_valid_nxt = s1_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) s1_item_r <= in_data;
    if (fire) meta_r <= meta_nxt;
  end

  urfw_fifo #(
    .DEPTH (RX_DEPTH)
  ) u_rx_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (rx_ctrl),
    .cap_in  (cfg_data),
    .wr_data (s1_item_r.data_in),
    .rd_data (rx_rd),
    .stat    (rx_stat)
  );

  urfw_fifo #(
    .DEPTH (TX_DEPTH)
  ) u_tx_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (tx_ctrl),
    .cap_in  (cfg_data),
    .wr_data (s1_item_r.data_in),
    .rd_data (tx_rd),
    .stat    (tx_stat)
  );

  // The popped byte sits in the read register of the FIFO it came from, which
  // holds still for as long as the result waits.
  assign out_valid           = out_valid_r;
  assign out_data.data_out   = !meta_r.data_valid ? 8'd0 : (meta_r.src_tx ? tx_rd : rx_rd);
  assign out_data.data_valid = meta_r.data_valid;
  assign out_data.accepted   = meta_r.accepted;
  assign out_data.rx_event   = meta_r.rx_event;
  assign out_data.tx_done    = meta_r.tx_done;
  assign out_data.rx_level   = meta_r.rx_level;
  assign out_data.tx_level   = meta_r.tx_level;

endmodule

### design/urfw_fifo.sv
// ----------------------------------------------------------------------------
// urfw_fifo
// Byte ring FIFO with a programmable usable capacity and a registered read.
// ----------------------------------------------------------------------------
module urfw_fifo import urfw_pkg::*; #(
  parameter int unsigned DEPTH = RX_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  fifo_ctrl_t       ctrl,
  input  logic [CNT_W-1:0] cap_in,
  input  logic [7:0]       wr_data,
  output logic [7:0]       rd_data,
  output fifo_stat_t       stat
);

  localparam int unsigned EFF = (DEPTH < CAP_MAX) ? DEPTH : CAP_MAX;
  localparam int unsigned AW  = $clog2(EFF);
  localparam int unsigned PAD = CNT_W - AW;
  localparam logic [CNT_W-1:0] CAP_RST = CNT_W'(EFF);

  logic [7:0]       mem [EFF];
  logic [7:0]       rd_data_r;
  logic [AW-1:0]    head_r, head_nxt;
  logic [AW-1:0]    tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] cap_r, cap_nxt;
  logic [CNT_W-1:0] head_inc, tail_inc;

  assign head_inc = {{PAD{1'b0}}, head_r} + 9'd1;
  assign tail_inc = {{PAD{1'b0}}, tail_r} + 9'd1;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    cap_nxt   = cap_r;
    if (ctrl.clear) begin
      head_nxt  = '0;
      tail_nxt  = '0;
      count_nxt = '0;
      cap_nxt   = clamp_cap(cap_in, EFF);
    end else begin
      if (ctrl.push) begin
        head_nxt  = (head_inc >= cap_r) ? '0 : head_inc[AW-1:0];
        count_nxt = count_r + 9'd1;
      end
      if (ctrl.pop) begin
        tail_nxt  = (tail_inc >= cap_r) ? '0 : tail_inc[AW-1:0];
        count_nxt = count_r - 9'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      cap_r   <= CAP_RST;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      cap_r   <= cap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push && !ctrl.clear) mem[head_r] <= wr_data;
    if (ctrl.pop && !ctrl.clear) rd_data_r <= mem[tail_r];
  end

  assign rd_data        = rd_data_r;
  assign stat.count     = count_r;
  assign stat.count_nxt = count_nxt;
  assign stat.cap       = cap_r;

endmodule

### sim/tb_uart_ring_fifo_with_watermarks.sv
// ----------------------------------------------------------------------------
// tb_uart_ring_fifo_with_watermarks
// Self-checking bench for the UART receive and transmit ring FIFOs. A
// directed opening covers empty pops, full drops, watermark and idle events
// and the unused operation codes. Random traffic then runs under several
// capacity settings, with random gaps and output stalls. Every result is
// checked field by field against a cycle-free model of both rings.
// ----------------------------------------------------------------------------
module tb_uart_ring_fifo_with_watermarks;
  import urfw_pkg::*;

  // Operation codes that the block decodes as no-ops.
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  // Cycles without any transaction or register write before the run is
  // declared hung.
  localparam int QUIET_LIMIT = 2000;

  // Traffic mixes for the random part.
  localparam int MIX_FILL  = 0;
  localparam int MIX_DRAIN = 1;
  localparam int MIX_EVEN  = 2;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_we    = 1'b0;
  logic      cfg_index = REG_RX_CAP;
  logic [CNT_W-1:0] cfg_data = '0;

  uart_ring_fifo_with_watermarks u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Ring model. Both FIFOs are tracked with their own write slot, read slot,
  // fill level and capacity, exactly as the hardware should see them after
  // each accepted transaction.
  // --------------------------------------------------------------------------
  logic [7:0] rx_ring [256];
  logic [7:0] tx_ring [256];
  int rx_wr, rx_rd, rx_fill, rx_cap = 256;
  int tx_wr, tx_rd, tx_fill, tx_cap = 256;

  in_item_t  pending_items [$];
  out_item_t expected_results [$];
  out_item_t want;
  int        fail_count = 0;
  int        quiet_cycles = 0;
  logic      in_acc = 1'b0;

  // A zero capacity reads as one; anything past the ring depth saturates.
  function automatic int clamp_capacity(logic [CNT_W-1:0] value);
    if (value == '0) return 1;
    if (value > 9'd256) return 256;
    return int'(value);
  endfunction

  function automatic int next_slot(int slot, int cap);
    return (slot + 1 >= cap) ? 0 : slot + 1;
  endfunction

  // Applies one transaction to the ring model and returns the result the
  // block must produce for it.
  function automatic out_item_t step_fifos(in_item_t item);
    out_item_t r;
    r = '0;
    case (item.operation)
      OP_LINE_RX: begin
        // A byte arriving at a full receive ring is dropped; accepted stays low and no event is raised.
        if (rx_fill < rx_cap) begin
          rx_ring[rx_wr] = item.data_in;
          rx_wr = next_slot(rx_wr, rx_cap);
          rx_fill++;
          r.accepted = 1'b1;
          if (rx_fill == rx_cap) r.rx_event = EVT_FULL;
          else if (rx_fill > rx_cap / 2) r.rx_event = EVT_HALF;
        end
      end
      OP_IDLE: begin
        if (rx_fill <= rx_cap / 2) r.rx_event = EVT_IDLE;
      end
      OP_TX_READY: begin
        if (tx_fill != 0) begin
          r.data_out = tx_ring[tx_rd];
          r.data_valid = 1'b1;
          tx_rd = next_slot(tx_rd, tx_cap);
          tx_fill--;
          r.tx_done = (tx_fill == 0);
        end
      end
      OP_HOST_READ: begin
        if (rx_fill != 0) begin
          r.data_out = rx_ring[rx_rd];
          r.data_valid = 1'b1;
          rx_rd = next_slot(rx_rd, rx_cap);
          rx_fill--;
        end
      end
      OP_HOST_WRITE: begin
        if (tx_fill < tx_cap) begin
          tx_ring[tx_wr] = item.data_in;
          tx_wr = next_slot(tx_wr, tx_cap);
          tx_fill++;
          r.accepted = 1'b1;
        end
      end
      default: begin
        // Spare codes leave both rings alone and report only the levels.
      end
    endcase
    r.rx_level = CNT_W'(rx_fill);
    r.tx_level = CNT_W'(tx_fill);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Random helpers.
  // --------------------------------------------------------------------------

  // Idle length between transactions: mostly none, sometimes short, rarely
  // long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // One random transaction, weighted toward filling, draining or an even mix.
  function automatic in_item_t pick_item(int mix);
    in_item_t item;
    int roll;
    item.data_in = 8'($urandom_range(0, 255));
    roll = $urandom_range(0, 99);
    if (roll >= 97) begin
      item.operation = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    end else if (mix == MIX_FILL) begin
      if (roll < 45) item.operation = OP_LINE_RX;
      else if (roll < 85) item.operation = OP_HOST_WRITE;
      else if (roll < 90) item.operation = OP_IDLE;
      else if (roll < 94) item.operation = OP_HOST_READ;
      else item.operation = OP_TX_READY;
    end else if (mix == MIX_DRAIN) begin
      if (roll < 8) item.operation = OP_LINE_RX;
      else if (roll < 16) item.operation = OP_HOST_WRITE;
      else if (roll < 24) item.operation = OP_IDLE;
      else if (roll < 60) item.operation = OP_HOST_READ;
      else item.operation = OP_TX_READY;
    end else begin
      if (roll < 22) item.operation = OP_LINE_RX;
      else if (roll < 32) item.operation = OP_IDLE;
      else if (roll < 54) item.operation = OP_TX_READY;
      else if (roll < 76) item.operation = OP_HOST_READ;
      else item.operation = OP_HOST_WRITE;
    end
    return item;
  endfunction

  task automatic add_item(logic [2:0] op, logic [7:0] value);
    in_item_t item;
    item.operation = op;
    item.data_in = value;
    pending_items.push_back(item);
  endtask

  // Random traffic whose mix is redrawn every sixteen transactions, so that the
  // rings swing between empty and full rather than hovering at one level.
  task automatic add_random(int count);
    int mix;
    mix = MIX_EVEN;
    for (int i = 0; i < count; i++) begin
      if (i % 16 == 0) mix = $urandom_range(MIX_FILL, MIX_EVEN);
      pending_items.push_back(pick_item(mix));
    end
  endtask

  // Blocks until every queued transaction has gone in and every result has
  // come out, then lets the pipeline settle.
  task automatic wait_quiet();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Register write while the block is idle. The model clears the matching
  // ring at the same edge as the hardware.
  task automatic set_capacity(cfg_reg_t which, logic [CNT_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= which;
    cfg_data <= value;
    @(posedge clk);
    if (which == REG_RX_CAP) begin
      rx_cap = clamp_capacity(value);
      rx_wr = 0;
      rx_rd = 0;
      rx_fill = 0;
    end else begin
      tx_cap = clamp_capacity(value);
      tx_wr = 0;
      tx_rd = 0;
      tx_fill = 0;
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic check_field(string name, int expected, int actual);
    if (expected != actual) begin
      $display("%0t: mismatch on %s, expected %0d, actual %0d",
               $time, name, expected, actual);
      fail_count++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Input driver. A new transaction is presented at a falling edge only when
  // the previous one was taken (or none was pending), so a stalled payload
  // never changes. Gaps are drawn per transaction, and now and then a calm
  // stretch of back-to-back traffic is forced.
  // --------------------------------------------------------------------------
  int send_wait = 0;
  int send_calm = 0;

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_acc)) begin
      if (send_wait > 0) begin
        in_valid <= 1'b0;
        send_wait--;
      end else if (pending_items.size() != 0) begin
        in_valid <= 1'b1;
        in_data <= pending_items.pop_front();
        if (send_calm > 0) begin
          send_calm--;
        end else begin
          send_wait = pick_gap();
          if ($urandom_range(0, 31) == 0) send_calm = $urandom_range(30, 80);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result-side back-pressure, drawn the same way as the input gaps.
  int stall_left = 0;
  int stall_calm = 0;

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (stall_calm > 0) begin
        stall_calm--;
      end else begin
        stall_left = pick_gap();
        if ($urandom_range(0, 31) == 0) stall_calm = $urandom_range(30, 80);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sampling at the rising edge. An accepted input transaction is run through
  // the model first, so its expectation is queued before any result of the
  // same edge is compared. The watchdog counts edges at which nothing moved.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    in_acc <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) expected_results.push_back(step_fifos(in_data));

      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h",
                   $time, out_data);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("data_out", want.data_out, out_data.data_out);
          check_field("data_valid", want.data_valid, out_data.data_valid);
          check_field("accepted", want.accepted, out_data.accepted);
          check_field("rx_event", want.rx_event, out_data.rx_event);
          check_field("tx_done", want.tx_done, out_data.tx_done);
          check_field("rx_level", want.rx_level, out_data.rx_level);
          check_field("tx_level", want.tx_level, out_data.tx_level);
        end
      end

      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: timeout, no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset capacities. Pops from empty rings, idle at an empty ring, the
    // spare codes, byte extremes on both rings, and the transmit ring
    // draining to empty with the done flag on the last pop.
    add_item(OP_HOST_READ, 8'h00);
    add_item(OP_TX_READY, 8'hFF);
    add_item(OP_IDLE, 8'h00);
    add_item(OP_SPARE_LO, 8'h00);
    add_item(OP_SPARE_LO + 3'd1, 8'hFF);
    add_item(OP_SPARE_HI, 8'h55);
    add_item(OP_LINE_RX, 8'h00);
    add_item(OP_LINE_RX, 8'hFF);
    add_item(OP_HOST_WRITE, 8'hFF);
    add_item(OP_HOST_WRITE, 8'h00);
    add_item(OP_TX_READY, 8'h00);
    add_item(OP_TX_READY, 8'h00);
    add_item(OP_IDLE, 8'hAA);
    add_item(OP_HOST_READ, 8'h00);
    add_item(OP_HOST_READ, 8'h00);
    wait_quiet();

    // A zero capacity reads as one entry. A single byte fills the receive
    // ring, the next is dropped, and a second host write is refused.
    set_capacity(REG_RX_CAP, 9'd0);
    set_capacity(REG_TX_CAP, 9'd1);
    add_item(OP_LINE_RX, 8'hA5);
    add_item(OP_LINE_RX, 8'h5A);
    add_item(OP_IDLE, 8'h00);
    add_item(OP_HOST_WRITE, 8'h3C);
    add_item(OP_HOST_WRITE, 8'hC3);
    add_item(OP_HOST_READ, 8'h00);
    add_item(OP_TX_READY, 8'h00);
    add_item(OP_IDLE, 8'h00);
    wait_quiet();

    // Small odd and even rings, so that the half mark, the full mark and
    // pointer wrap all come up often.
    set_capacity(REG_RX_CAP, 9'd3);
    set_capacity(REG_TX_CAP, 9'd2);
    add_random(150);
    wait_quiet();

    // Oversized values saturate to the full ring. The receive ring is filled
    // to the top and overrun, then worked from there.
    set_capacity(REG_RX_CAP, 9'd511);
    set_capacity(REG_TX_CAP, 9'd300);
    for (int i = 0; i < 258; i++) add_item(OP_LINE_RX, 8'($urandom_range(0, 255)));
    add_item(OP_IDLE, 8'h00);
    add_random(60);
    wait_quiet();

    // Random small capacities.
    for (int round = 0; round < 2; round++) begin
      set_capacity(REG_RX_CAP, 9'($urandom_range(1, 40)));
      set_capacity(REG_TX_CAP, 9'($urandom_range(1, 40)));
      add_random(85);
      wait_quiet();
    end

    // Back to the exact maximum written directly.
    set_capacity(REG_RX_CAP, 9'd256);
    set_capacity(REG_TX_CAP, 9'd256);
    add_random(80);
    wait_quiet();

    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### uart_ring_fifo_with_watermarks.f
design/urfw_pkg.sv
design/urfw_fifo.sv
design/uart_ring_fifo_with_watermarks.sv
sim/tb_uart_ring_fifo_with_watermarks.sv
